// ===== src/texture_slab_bump_allocator_macros.svh =====
// Assertion macros used by the slab allocator top level.
`ifndef TEXTURE_SLAB_BUMP_ALLOCATOR_MACROS_SVH
`define TEXTURE_SLAB_BUMP_ALLOCATOR_MACROS_SVH
// Assert that a condition implies a consequence in the same cycle.
`define TSBA_ASSERT_IMP(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");
// Assert that a condition implies a consequence in the next cycle.
`define TSBA_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`endif

// ===== src/tsba_pkg.sv =====
// Package with types and constants of the texture slab allocator.
`timescale 1ns / 1ps
package tsba_pkg;
    localparam int MaxSlabs = 16;
    localparam int SlotW = $clog2(MaxSlabs);
    localparam int CountW = $clog2(MaxSlabs + 1);
    localparam int LenW = 27;
    localparam int UsersW = 18;
    localparam logic [LenW-1:0] MinSlabReset = 27'd8388608;
    localparam logic [12:0] MaxDimReset = 13'd4096;
    localparam logic CfgMinSlab = 1'b0;
    localparam logic CfgMaxDim = 1'b1;

    typedef struct packed {
        logic [31:0]       start;
        logic [LenW-1:0]   length;
        logic [LenW-1:0]   fill;
        logic [UsersW-1:0] users;
    } slab_t;

    // Command broadcast to every cell of the chain.
    typedef enum logic [2:0] {
        CMD_IDLE, CMD_SCAN, CMD_BUMP, CMD_OPEN, CMD_DEC, CMD_SHIFT
    } cmd_t;

    typedef struct packed {
        cmd_t            cmd;
        logic [SlotW-1:0] slot;
        logic [LenW-1:0] need;
        logic [31:0]     addr;
        logic [31:0]     base;
        logic [LenW-1:0] len;
    } cell_ctl_t;
endpackage

// ===== src/tsba_cell.sv =====
// One slab cell: holds one slab and flags a fit or an address hit for it.
`timescale 1ns / 1ps
module tsba_cell
    import tsba_pkg::*;
(
    input  logic             clk,
    input  logic [SlotW-1:0] my_slot,
    input  cell_ctl_t        ctl,
    input  slab_t            right,
    output slab_t            slab,
    output logic             fits,
    output logic             holds
);
    slab_t slab_reg;
    logic [LenW:0] sum;

    assign slab = slab_reg;
    assign sum = {1'b0, slab_reg.fill} + {1'b0, ctl.need};
    assign fits = sum <= {1'b0, slab_reg.length};
    assign holds = (ctl.addr >= slab_reg.start) &&
        ({1'b0, ctl.addr} < ({1'b0, slab_reg.start} + {6'd0, slab_reg.length}));

    always_ff @(posedge clk)
    begin
        case (ctl.cmd)
            CMD_BUMP:
            begin
                if (ctl.slot == my_slot)
                begin
                    slab_reg.fill <= sum[LenW-1:0];
                    if (slab_reg.users != '1)
                        slab_reg.users <= slab_reg.users + 1'b1;
                end
            end
            CMD_OPEN:
            begin
                if (ctl.slot == my_slot)
                begin
                    slab_reg.start <= ctl.base;
                    slab_reg.length <= ctl.len;
                    slab_reg.fill <= ctl.need;
                    slab_reg.users <= UsersW'(1);
                end
            end
            CMD_DEC:
            begin
                if (ctl.slot == my_slot && slab_reg.users != '0)
                    slab_reg.users <= slab_reg.users - 1'b1;
            end
            CMD_SHIFT:
            begin
                if (my_slot >= ctl.slot)
                    slab_reg <= right;
            end
            default:
            begin
            end
        endcase
    end
endmodule

// ===== src/texture_slab_bump_allocator.sv =====
// Top level of the texture slab bump allocator.
`timescale 1ns / 1ps
// The block keeps up to 16 slabs in a chain of cells, one slab per cell. A
// request word passes through these steps from its acceptance to its result
// word: a sizing state (one 14 by 13 bit multiply), then a walk of one cell per
// cycle over the occupied slabs until a match, or to one past the last occupied
// slab when nothing matches (an oversized allocation skips the walk), then an
// update of the chosen cell, on a freed slab a shift in which the freed cell and
// every later cell take their right neighbor's contents, and a state that posts
// the result. The input is stalled from acceptance until the result is posted.
// Exactly one result word is produced per request and held in an output
// register. A new request may be taken while a result still waits, but it holds
// in the sizing state until that result has left. Configuration is written
// through its own valid/ready port and is always ready.
`include "texture_slab_bump_allocator_macros.svh"
module texture_slab_bump_allocator
    import tsba_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        req_type,
    input  logic [12:0] tex_width,
    input  logic [12:0] tex_height,
    input  logic [2:0]  bytes_per_pixel,
    input  logic [31:0] release_address,
    input  logic [31:0] backing_base,
    input  logic        backing_ok,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        alloc_ok,
    output logic [31:0] alloc_address,
    output logic        slab_opened,
    output logic [26:0] opened_slab_bytes,
    output logic        slab_freed,
    output logic [31:0] freed_slab_base
);
    typedef enum logic [2:0] {ST_IDLE, ST_SIZE, ST_SCAN, ST_ACT, ST_SHIFT, ST_DONE} state_t;

    state_t state_reg;
    logic [LenW-1:0] min_slab_reg;
    logic [12:0] max_dim_reg;
    logic [CountW-1:0] count_reg;
    logic [CountW-1:0] idx_reg;
    logic req_type_reg, backing_ok_reg, oversize_reg;
    logic [12:0] width_reg, height_reg;
    logic [2:0] bpp_reg;
    logic [31:0] addr_reg, base_reg;
    logic [LenW-1:0] need_reg;
    logic [LenW-1:0] len_reg;
    logic found_reg;
    logic res_ok_reg, res_open_reg, res_free_reg;
    logic [31:0] res_addr_reg, res_fbase_reg;
    logic [LenW-1:0] res_len_reg;
    logic out_valid_reg;

    cell_ctl_t ctl;
    slab_t slabs [MaxSlabs];
    slab_t rights [MaxSlabs];
    logic [MaxSlabs-1:0] fits, holds;
    slab_t cur;
    logic cur_fit, cur_hold;
    logic [SlotW-1:0] slot;

    // Size calculation: rounded width times height, scaled by pixel size, then rounded up to a multiple of 64.
    // A width of 8191 rounds up to 8192, so the rounded width needs 14 bits.
    logic [13:0] wround;
    logic [26:0] prod;
    logic [28:0] scaled;
    logic [29:0] aligned;
    assign wround = ((14'(width_reg) + 14'd7) >> 3) << 3;
    assign prod = 27'(wround) * 27'(height_reg);
    always_comb
    begin
        case (bpp_reg)
            3'd1: scaled = 29'(prod);
            3'd2: scaled = {1'b0, prod, 1'b0};
            default: scaled = {prod, 2'b0};
        endcase
    end
    assign aligned = ((30'(scaled) + 30'd63) >> 6) << 6;

    assign slot = idx_reg[SlotW-1:0];

    genvar g;
    generate
        for (g = 0; g < MaxSlabs; g++)
        begin : g_cell
            if (g == MaxSlabs - 1)
            begin : g_last
                assign rights[g] = slabs[g];
            end
            else
            begin : g_mid
                assign rights[g] = slabs[g+1];
            end
            tsba_cell u_cell (
                .clk     (clk),
                .my_slot (SlotW'(g)),
                .ctl     (ctl),
                .right   (rights[g]),
                .slab    (slabs[g]),
                .fits    (fits[g]),
                .holds   (holds[g])
            );
        end
    endgenerate

    assign cur = slabs[slot];
    assign cur_fit = fits[slot];
    assign cur_hold = holds[slot];

    always_comb
    begin
        ctl.cmd = CMD_IDLE;
        ctl.slot = slot;
        ctl.need = need_reg;
        ctl.addr = addr_reg;
        ctl.base = base_reg;
        ctl.len = len_reg;
        if (state_reg == ST_ACT)
        begin
            if (!req_type_reg && found_reg)
                ctl.cmd = CMD_BUMP;
            else if (!req_type_reg && res_open_reg)
                ctl.cmd = CMD_OPEN;
            else if (req_type_reg && found_reg)
                ctl.cmd = CMD_DEC;
        end
        else if (state_reg == ST_SHIFT)
            ctl.cmd = CMD_SHIFT;
    end

    assign cfg_ready = 1'b1;
    assign in_stall = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign alloc_ok = res_ok_reg;
    assign alloc_address = res_addr_reg;
    assign slab_opened = res_open_reg;
    assign opened_slab_bytes = res_len_reg;
    assign slab_freed = res_free_reg;
    assign freed_slab_base = res_fbase_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            min_slab_reg <= MinSlabReset;
            max_dim_reg <= MaxDimReset;
            count_reg <= '0;
            idx_reg <= '0;
            out_valid_reg <= 1'b0;
            found_reg <= 1'b0;
            res_open_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    CfgMinSlab: min_slab_reg <= cfg_data[LenW-1:0];
                    CfgMaxDim:  max_dim_reg <= cfg_data[12:0];
                    default: ;
                endcase
            end
            // The output register is always empty by the time a result is posted.
            if (state_reg == ST_DONE)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        req_type_reg <= req_type;
                        width_reg <= tex_width;
                        height_reg <= tex_height;
                        bpp_reg <= bytes_per_pixel;
                        addr_reg <= release_address;
                        base_reg <= backing_base;
                        backing_ok_reg <= backing_ok;
                        oversize_reg <= (tex_width > max_dim_reg) ||
                            (tex_height > max_dim_reg);
                        state_reg <= ST_SIZE;
                    end
                end
                ST_SIZE:
                begin
                    // Wait here while an earlier result word still sits in the
                    // output register, since the update cycle overwrites it.
                    if (!out_valid_reg || !out_stall)
                    begin
                        need_reg <= aligned[LenW-1:0];
                        if (!req_type_reg && (oversize_reg || aligned[29:LenW] != '0))
                            oversize_reg <= 1'b1;
                        idx_reg <= '0;
                        found_reg <= 1'b0;
                        res_open_reg <= 1'b0;
                        state_reg <= ST_SCAN;
                    end
                end
                ST_SCAN:
                begin
                    if (!req_type_reg && oversize_reg)
                        state_reg <= ST_ACT;
                    else if (idx_reg >= count_reg)
                    begin
                        if (!req_type_reg && count_reg < CountW'(MaxSlabs) &&
                            backing_ok_reg)
                        begin
                            res_open_reg <= 1'b1;
                            len_reg <= (need_reg > min_slab_reg) ? need_reg : min_slab_reg;
                        end
                        state_reg <= ST_ACT;
                    end
                    else if ((!req_type_reg && cur_fit) || (req_type_reg && cur_hold))
                    begin
                        found_reg <= 1'b1;
                        state_reg <= ST_ACT;
                    end
                    else
                        idx_reg <= idx_reg + 1'b1;
                end
                ST_ACT:
                begin
                    if (!req_type_reg && !oversize_reg && found_reg)
                    begin
                        res_ok_reg <= 1'b1;
                        res_addr_reg <= cur.start + {5'd0, cur.fill};
                        res_len_reg <= '0;
                        res_free_reg <= 1'b0;
                        res_fbase_reg <= '0;
                        res_open_reg <= 1'b0;
                        state_reg <= ST_DONE;
                    end
                    else if (!req_type_reg && !oversize_reg && res_open_reg)
                    begin
                        res_ok_reg <= 1'b1;
                        res_addr_reg <= base_reg;
                        res_len_reg <= len_reg;
                        res_free_reg <= 1'b0;
                        res_fbase_reg <= '0;
                        count_reg <= count_reg + 1'b1;
                        state_reg <= ST_DONE;
                    end
                    else if (req_type_reg && found_reg && cur.users <= UsersW'(1))
                    begin
                        res_ok_reg <= 1'b0;
                        res_addr_reg <= '0;
                        res_len_reg <= '0;
                        res_free_reg <= 1'b1;
                        res_fbase_reg <= cur.start;
                        res_open_reg <= 1'b0;
                        state_reg <= ST_SHIFT;
                    end
                    else
                    begin
                        res_ok_reg <= 1'b0;
                        res_addr_reg <= '0;
                        res_len_reg <= '0;
                        res_free_reg <= 1'b0;
                        res_fbase_reg <= '0;
                        res_open_reg <= 1'b0;
                        state_reg <= ST_DONE;
                    end
                end
                ST_SHIFT:
                begin
                    count_reg <= count_reg - 1'b1;
                    state_reg <= ST_DONE;
                end
                ST_DONE:
                begin
                    state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    `TSBA_ASSERT_IMP(a_count_range, clk, rst_n, 1'b1, count_reg <= CountW'(MaxSlabs))
    `TSBA_ASSERT_IMP(a_one_result_kind, clk, rst_n, out_valid_reg,
        !(res_ok_reg && res_free_reg))
    `TSBA_ASSERT_NEXT(a_shift_drops, clk, rst_n, state_reg == ST_SHIFT,
        count_reg == $past(count_reg) - 1'b1)
    `TSBA_ASSERT_NEXT(a_hold_result, clk, rst_n, out_valid_reg && out_stall,
        out_valid_reg && $stable(res_addr_reg))
endmodule

// ===== tb/sv/tb_texture_slab_bump_allocator.sv =====
// Self-checking testbench for the texture slab bump allocator.
`timescale 1ns / 1ps
module tb_texture_slab_bump_allocator;
    import tsba_pkg::*;

    localparam logic REQ_ALLOC   = 1'b0;
    localparam logic REQ_RELEASE = 1'b1;
    localparam int   SLOTS       = 16;
    localparam int   RAND_WORDS  = 1880;
    localparam int   DRAIN_WAIT  = 40;

    // One request word as it is driven on the input channel.
    typedef struct {
        logic        kind;
        logic [12:0] width;
        logic [12:0] height;
        logic [2:0]  bpp;
        logic [31:0] rel_addr;
        logic [31:0] base;
        logic        base_ok;
    } request_t;

    // One result word as it leaves the block.
    typedef struct {
        logic        ok;
        logic [31:0] addr;
        logic        opened;
        logic [26:0] open_bytes;
        logic        freed;
        logic [31:0] freed_base;
    } grant_t;

    // A row of the directed table: the request and, where it is obvious,
    // the result typed in by hand.
    typedef struct {
        request_t req;
        bit       pinned;
        grant_t   res;
    } row_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [31:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic        req_type;
    logic [12:0] tex_width;
    logic [12:0] tex_height;
    logic [2:0]  bytes_per_pixel;
    logic [31:0] release_address;
    logic [31:0] backing_base;
    logic        backing_ok;
    logic        out_valid;
    logic        out_stall;
    logic        alloc_ok;
    logic [31:0] alloc_address;
    logic        slab_opened;
    logic [26:0] opened_slab_bytes;
    logic        slab_freed;
    logic [31:0] freed_slab_base;

    texture_slab_bump_allocator DUT (.*);

    // Shadow copy of the slab table and the two registers.
    logic [26:0] min_slab;
    logic [12:0] max_dim;
    int          live_slabs;
    logic [31:0] sh_start [SLOTS];
    logic [26:0] sh_length[SLOTS];
    logic [26:0] sh_fill  [SLOTS];
    logic [17:0] sh_users [SLOTS];

    grant_t      pending_grants[$];
    logic [31:0] granted_addrs[$];
    bit          pin_next;
    grant_t      pin_res;
    int          errors;

    initial clk = 1'b0;
    always #10 clk = ~clk;

    // Work out the result of one request and advance the shadow table.
    function automatic grant_t slab_table_step(request_t r);
        grant_t      g;
        logic [63:0] w;
        logic [63:0] h;
        logic [63:0] bpp;
        logic [63:0] need;
        logic [63:0] len;
        logic [63:0] a;
        bit          done;
        g = '{default: '0};
        done = 0;
        if (r.kind == REQ_ALLOC)
        begin
            w = r.width;
            h = r.height;
            bpp = (r.bpp == 3'd1 || r.bpp == 3'd2) ? r.bpp : 64'd4;
            need = ((w + 7) / 8) * 8 * h * bpp;
            need = ((need + 63) / 64) * 64;
            if (r.width > max_dim || r.height > max_dim || need > 64'h7FF_FFFF)
                return g;
            for (int i = 0; i < live_slabs && !done; i++)
            begin
                if (64'(sh_fill[i]) + need <= 64'(sh_length[i]))
                begin
                    g.ok = 1'b1;
                    g.addr = sh_start[i] + 32'(sh_fill[i]);
                    sh_fill[i] = sh_fill[i] + 27'(need);
                    if (sh_users[i] != 18'h3FFFF)
                        sh_users[i]++;
                    done = 1;
                end
            end
            if (!done && live_slabs < SLOTS && r.base_ok)
            begin
                len = (need > 64'(min_slab)) ? need : 64'(min_slab);
                sh_start[live_slabs] = r.base;
                sh_length[live_slabs] = 27'(len);
                sh_fill[live_slabs] = 27'(need);
                sh_users[live_slabs] = 18'd1;
                live_slabs++;
                g.ok = 1'b1;
                g.addr = r.base;
                g.opened = 1'b1;
                g.open_bytes = 27'(len);
            end
        end
        else
        begin
            a = r.rel_addr;
            for (int i = 0; i < live_slabs && !done; i++)
            begin
                if (a >= 64'(sh_start[i]) && a < 64'(sh_start[i]) + 64'(sh_length[i]))
                begin
                    done = 1;
                    if (sh_users[i] != 0)
                        sh_users[i]--;
                    if (sh_users[i] == 0)
                    begin
                        g.freed = 1'b1;
                        g.freed_base = sh_start[i];
                        for (int j = i; j + 1 < live_slabs; j++)
                        begin
                            sh_start[j] = sh_start[j + 1];
                            sh_length[j] = sh_length[j + 1];
                            sh_fill[j] = sh_fill[j + 1];
                            sh_users[j] = sh_users[j + 1];
                        end
                        live_slabs--;
                    end
                end
            end
        end
        return g;
    endfunction

    // Accepted request words are predicted on the same edge that takes them.
    // A pinned row from the directed table replaces the prediction, though the
    // shadow table still advances.
    always @(posedge clk)
    begin
        request_t r;
        grant_t   g;
        if (rst_n && in_valid && !in_stall)
        begin
            r = '{req_type, tex_width, tex_height, bytes_per_pixel,
                  release_address, backing_base, backing_ok};
            g = slab_table_step(r);
            if (g.ok)
                granted_addrs.insert(granted_addrs.size(), g.addr);
            if (pin_next)
                pending_grants.insert(pending_grants.size(), pin_res);
            else
                pending_grants.insert(pending_grants.size(), g);
        end
        if (rst_n && cfg_valid && cfg_ready)
        begin
            if (cfg_index == CfgMinSlab)
                min_slab = cfg_data[26:0];
            else
                max_dim = cfg_data[12:0];
        end
    end

    // Result words are compared field by field against the oldest expectation.
    always @(posedge clk)
    begin
        grant_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_grants.size() == 0)
            begin
                $display("%0t: result word with nothing expected", $time);
                errors++;
            end
            else
            begin
                e = pending_grants.pop_front();
                if (alloc_ok !== e.ok)
                begin
                    $display("%0t: alloc_ok expected %0h actual %0h", $time, e.ok, alloc_ok);
                    errors++;
                end
                if (alloc_address !== e.addr)
                begin
                    $display("%0t: alloc_address expected %0h actual %0h",
                             $time, e.addr, alloc_address);
                    errors++;
                end
                if (slab_opened !== e.opened)
                begin
                    $display("%0t: slab_opened expected %0h actual %0h",
                             $time, e.opened, slab_opened);
                    errors++;
                end
                if (opened_slab_bytes !== e.open_bytes)
                begin
                    $display("%0t: opened_slab_bytes expected %0h actual %0h",
                             $time, e.open_bytes, opened_slab_bytes);
                    errors++;
                end
                if (slab_freed !== e.freed)
                begin
                    $display("%0t: slab_freed expected %0h actual %0h",
                             $time, e.freed, slab_freed);
                    errors++;
                end
                if (freed_slab_base !== e.freed_base)
                begin
                    $display("%0t: freed_slab_base expected %0h actual %0h",
                             $time, e.freed_base, freed_slab_base);
                    errors++;
                end
            end
        end
    end

    // The result side stalls in bursts: long runs free of stalls, short
    // stalls most of the time it does stall, and now and then a long one.
    initial
    begin
        int n;
        out_stall = 1'b0;
        forever
        begin
            n = $urandom_range(1, 40);
            repeat (n) @(negedge clk);
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: n = 0;
                5, 6, 7, 8:    n = $urandom_range(1, 4);
                default:       n = $urandom_range(10, 60);
            endcase
            if (n > 0)
            begin
                out_stall = 1'b1;
                repeat (n) @(negedge clk);
                out_stall = 1'b0;
            end
        end
    end

    // Drive one word at the falling edge and hold it until it is taken.
    // A random gap may follow, which decides whether valid drops.
    task automatic send_word(request_t r, bit pinned, grant_t res);
        int gap;
        @(negedge clk);
        req_type = r.kind;
        tex_width = r.width;
        tex_height = r.height;
        bytes_per_pixel = r.bpp;
        release_address = r.rel_addr;
        backing_base = r.base;
        backing_ok = r.base_ok;
        pin_next = pinned;
        pin_res = res;
        in_valid = 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: gap = 0;
            6, 7, 8:          gap = $urandom_range(1, 3);
            default:          gap = $urandom_range(8, 60);
        endcase
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid = 1'b0;
            pin_next = 0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    // Let every outstanding result come back, then leave some slack cycles.
    task automatic wait_idle();
        while (pending_grants.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [31:0] value);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = value;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Build a random word. Most allocations are small so slabs fill and
    // release cleanly; releases mostly target a granted address.
    function automatic request_t random_word();
        request_t r;
        int       k;
        r.kind = ($urandom_range(0, 99) < 45) ? REQ_RELEASE : REQ_ALLOC;
        if ($urandom_range(0, 9) == 0)
        begin
            r.width = 13'($urandom);
            r.height = 13'($urandom);
        end
        else
        begin
            r.width = 13'($urandom_range(0, 80));
            r.height = 13'($urandom_range(0, 80));
        end
        r.bpp = 3'($urandom);
        r.base = $urandom;
        r.base_ok = ($urandom_range(0, 9) != 0);
        r.rel_addr = $urandom;
        if (r.kind == REQ_RELEASE && granted_addrs.size() > 0 && $urandom_range(0, 9) < 8)
        begin
            k = $urandom_range(0, granted_addrs.size() - 1);
            r.rel_addr = granted_addrs[k];
            granted_addrs.delete(k);
        end
        return r;
    endfunction

    // Directed table: an empty-table release, the dimension limit, a zero-sized
    // request opening and then sharing a slab, missing backing, the largest
    // legal request, other pixel sizes, freeing, a stray release, and an
    // address that wraps past the top of the address space.
    row_t directed[] = '{
        '{'{REQ_RELEASE, 13'd0, 13'd0, 3'd1, 32'h0, 32'h0, 1'b1}, 1,
          '{1'b0, 32'h0, 1'b0, 27'd0, 1'b0, 32'h0}},
        '{'{REQ_ALLOC, 13'd4097, 13'd1, 3'd1, 32'h0, 32'h500, 1'b1}, 1,
          '{1'b0, 32'h0, 1'b0, 27'd0, 1'b0, 32'h0}},
        '{'{REQ_ALLOC, 13'd0, 13'd5, 3'd1, 32'h0, 32'h1000, 1'b1}, 1,
          '{1'b1, 32'h1000, 1'b1, 27'd8388608, 1'b0, 32'h0}},
        '{'{REQ_ALLOC, 13'd7, 13'd0, 3'd2, 32'h0, 32'h2000, 1'b1}, 1,
          '{1'b1, 32'h1000, 1'b0, 27'd0, 1'b0, 32'h0}},
        '{'{REQ_ALLOC, 13'd4096, 13'd4096, 3'd4, 32'h0, 32'h3000, 1'b0}, 1,
          '{1'b0, 32'h0, 1'b0, 27'd0, 1'b0, 32'h0}},
        '{'{REQ_ALLOC, 13'd4096, 13'd4096, 3'd4, 32'h0, 32'hFFFF_F000, 1'b1}, 1,
          '{1'b1, 32'hFFFF_F000, 1'b1, 27'd67108864, 1'b0, 32'h0}},
        '{'{REQ_ALLOC, 13'd1, 13'd1, 3'd7, 32'h0, 32'h0, 1'b1}, 0, '{default: '0}},
        '{'{REQ_ALLOC, 13'd1, 13'd4096, 3'd3, 32'h0, 32'h0, 1'b1}, 0, '{default: '0}},
        '{'{REQ_ALLOC, 13'd9, 13'd3, 3'd0, 32'h0, 32'h0, 1'b1}, 0, '{default: '0}},
        '{'{REQ_RELEASE, 13'd0, 13'd0, 3'd1, 32'hFFFF_F000, 32'h0, 1'b1}, 1,
          '{1'b0, 32'h0, 1'b0, 27'd0, 1'b1, 32'hFFFF_F000}},
        '{'{REQ_RELEASE, 13'd0, 13'd0, 3'd1, 32'h0000_0FFF, 32'h0, 1'b1}, 1,
          '{1'b0, 32'h0, 1'b0, 27'd0, 1'b0, 32'h0}},
        '{'{REQ_RELEASE, 13'd0, 13'd0, 3'd1, 32'h1000, 32'h0, 1'b1}, 0, '{default: '0}},
        '{'{REQ_RELEASE, 13'd0, 13'd0, 3'd1, 32'h1040, 32'h0, 1'b1}, 0, '{default: '0}},
        '{'{REQ_RELEASE, 13'd0, 13'd0, 3'd1, 32'h107F_FFFF, 32'h0, 1'b1}, 0, '{default: '0}},
        '{'{REQ_RELEASE, 13'd0, 13'd0, 3'd1, 32'h1000, 32'h0, 1'b1}, 0, '{default: '0}},
        '{'{REQ_RELEASE, 13'd0, 13'd0, 3'd1, 32'h1000, 32'h0, 1'b1}, 0, '{default: '0}},
        '{'{REQ_ALLOC, 13'd4096, 13'd4096, 3'd2, 32'h0, 32'hFFFF_FFC0, 1'b1}, 0,
          '{default: '0}},
        '{'{REQ_ALLOC, 13'd8, 13'd8, 3'd1, 32'h0, 32'h0, 1'b1}, 0, '{default: '0}},
        '{'{REQ_RELEASE, 13'd0, 13'd0, 3'd1, 32'hFFFF_FFC0, 32'h0, 1'b1}, 0, '{default: '0}}
    };

    // Register settings for the random phases, the extremes among them.
    logic [26:0] phase_min[] = '{27'd64, 27'd67108864, 27'd4096, 27'd64, 27'd1024};
    logic [12:0] phase_dim[] = '{13'd8191, 13'd1, 13'd300, 13'd64, 13'd8191};

    initial
    begin
        int per_phase;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CfgMinSlab;
        cfg_data = '0;
        in_valid = 1'b0;
        req_type = REQ_ALLOC;
        tex_width = '0;
        tex_height = '0;
        bytes_per_pixel = 3'd1;
        release_address = '0;
        backing_base = '0;
        backing_ok = 1'b0;
        pin_next = 0;
        pin_res = '{default: '0};
        errors = 0;
        min_slab = MinSlabReset;
        max_dim = MaxDimReset;
        live_slabs = 0;
        for (int i = 0; i < SLOTS; i++)
        begin
            sh_start[i] = '0;
            sh_length[i] = '0;
            sh_fill[i] = '0;
            sh_users[i] = '0;
        end
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part runs with the reset register values.
        foreach (directed[i])
            send_word(directed[i].req, directed[i].pinned, directed[i].res);

        per_phase = RAND_WORDS / phase_min.size();
        foreach (phase_min[p])
        begin
            // Registers change only once the block has gone quiet.
            @(negedge clk);
            in_valid = 1'b0;
            pin_next = 0;
            wait_idle();
            write_reg(CfgMinSlab, 32'(phase_min[p]));
            write_reg(CfgMaxDim, 32'(phase_dim[p]));
            repeat (per_phase)
                send_word(random_word(), 0, '{default: '0});
        end

        @(negedge clk);
        in_valid = 1'b0;
        pin_next = 0;
        wait_idle();
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Watchdog well beyond the slowest legal run.
    initial
    begin
        #60ms;
        $display("*** FAILED ***");
        $finish;
    end
endmodule

// ===== filelist.f =====
+incdir+src
src/tsba_pkg.sv
src/tsba_cell.sv
src/texture_slab_bump_allocator.sv
tb/sv/tb_texture_slab_bump_allocator.sv
